/* design/lfdc_pkg.sv */
// Shared types, constants and the control program of the line-follow drive controller.
// Stands alone; the core module imports it.
`default_nettype none

package lfdc_pkg;

  // Widths of the stream payloads.
  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Program counter and divider widths.
  localparam int unsigned PC_W   = 4;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned QUO_W  = 37;
  localparam int unsigned DIVR_W = 48;

  // Iteration counts of the two divisions.
  localparam logic [CNT_W-1:0] SPD_ITERS = 6'd24;
  localparam logic [CNT_W-1:0] TRN_ITERS = 6'd37;

  // Angle wrap limits in Q3.13.
  localparam logic signed [17:0] ANG_PI     = 18'sd25736;
  localparam logic signed [17:0] ANG_TWO_PI = 18'sd51472;

  // Target speeds (Q8.8, unsigned) and turns (Q8.8, signed).
  localparam logic [9:0]         SPEED_ON_LINE  = 10'd768;
  localparam logic [9:0]         SPEED_OFF_LINE = 10'd512;
  localparam logic signed [11:0] TURN_HARD_L    = 12'sd1536;
  localparam logic signed [11:0] TURN_HARD_R    = -12'sd1536;
  localparam logic signed [11:0] TURN_SOFT_L    = 12'sd256;
  localparam logic signed [11:0] TURN_SOFT_R    = -12'sd256;
  localparam logic signed [11:0] TURN_NONE      = 12'sd0;

  // Remembered search turn, integer units.
  localparam logic signed [2:0] SEARCH_LEFT  = 3'sd3;
  localparam logic signed [2:0] SEARCH_RIGHT = -3'sd3;
  localparam logic signed [2:0] SEARCH_NONE  = 3'sd0;

  // Configuration register indices.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WHEEL_RADIUS = 3'd0,
    REG_WHEEL_BASE   = 3'd1,
    REG_FRONT_ALERT  = 3'd2,
    REG_FRONT_STOP   = 3'd3,
    REG_SIDE_ALERT   = 3'd4,
    REG_SIDE_TURN    = 3'd5
  } cfg_reg_e;

  // Datapath operation of one control word.
  typedef enum logic [3:0] {
    OP_WAIT      = 4'd0,
    OP_PREP      = 4'd1,
    OP_NOP       = 4'd2,
    OP_MUL_SUM   = 4'd3,
    OP_MUL_BDT   = 4'd4,
    OP_LOAD_SPD  = 4'd5,
    OP_DIV       = 4'd6,
    OP_STORE_SPD = 4'd7,
    OP_MUL_DIF   = 4'd8,
    OP_LOAD_TRN  = 4'd9,
    OP_STORE_TRN = 4'd10,
    OP_SUM       = 4'd11,
    OP_EMIT      = 4'd12
  } uop_e;

  // Sequencing rule of one control word.
  typedef enum logic [2:0] {
    SEQ_NEXT     = 3'd0,
    SEQ_WAIT_IN  = 3'd1,
    SEQ_JUMP_DT0 = 3'd2,
    SEQ_LOOP_DIV = 3'd3,
    SEQ_WAIT_OUT = 3'd4
  } seq_e;

  typedef struct packed {
    uop_e            op;
    seq_e            seq;
    logic [PC_W-1:0] target;
  } uword_t;

  localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
  localparam logic [PC_W-1:0] PC_LAST = 4'd13;

  // The control program: one word per step.
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      4'd0:    w = '{op: OP_WAIT,      seq: SEQ_WAIT_IN,  target: PC_IDLE};
      4'd1:    w = '{op: OP_PREP,      seq: SEQ_NEXT,     target: PC_IDLE};
      4'd2:    w = '{op: OP_NOP,       seq: SEQ_JUMP_DT0, target: PC_IDLE};
      4'd3:    w = '{op: OP_MUL_SUM,   seq: SEQ_NEXT,     target: PC_IDLE};
      4'd4:    w = '{op: OP_MUL_BDT,   seq: SEQ_NEXT,     target: PC_IDLE};
      4'd5:    w = '{op: OP_LOAD_SPD,  seq: SEQ_NEXT,     target: PC_IDLE};
      4'd6:    w = '{op: OP_DIV,       seq: SEQ_LOOP_DIV, target: PC_IDLE};
      4'd7:    w = '{op: OP_STORE_SPD, seq: SEQ_NEXT,     target: PC_IDLE};
      4'd8:    w = '{op: OP_MUL_DIF,   seq: SEQ_NEXT,     target: PC_IDLE};
      4'd9:    w = '{op: OP_LOAD_TRN,  seq: SEQ_NEXT,     target: PC_IDLE};
      4'd10:   w = '{op: OP_DIV,       seq: SEQ_LOOP_DIV, target: PC_IDLE};
      4'd11:   w = '{op: OP_STORE_TRN, seq: SEQ_NEXT,     target: PC_IDLE};
      4'd12:   w = '{op: OP_SUM,       seq: SEQ_NEXT,     target: PC_IDLE};
      4'd13:   w = '{op: OP_EMIT,      seq: SEQ_WAIT_OUT, target: PC_IDLE};
      default: w = '{op: OP_NOP,       seq: SEQ_JUMP_DT0, target: PC_IDLE};
    endcase
    return w;
  endfunction

  // Wheel angle change wrapped into plus or minus pi.
  function automatic logic signed [16:0] wrap_delta(input logic [15:0] now,
                                                    input logic [15:0] prev);
    logic signed [17:0] d;
    d = $signed({2'b00, now}) - $signed({2'b00, prev});
    if (d > ANG_PI) begin
      d = d - ANG_TWO_PI;
    end else if (d < -ANG_PI) begin
      d = d + ANG_TWO_PI;
    end
    return d[16:0];
  endfunction

  // Saturate a wide signed value to a 16-bit drive command.
  function automatic logic [15:0] sat16(input logic signed [39:0] v);
    logic [15:0] r;
    if (v > 40'sd32767) begin
      r = 16'h7FFF;
    end else if (v < -40'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/line_follow_drive_controller_core.sv */
// Line-follow drive controller: a microcoded sequencer over a small fixed-point datapath.
// Depends on lfdc_pkg for the control program, codes and helper functions.
//
// An input item runs through the whole program before the next one is taken; an item with
// zero elapsed time gives no result and the program goes straight back to its wait step.
// Both divisions share one one-bit-per-cycle divider
// (24 steps for the speed estimate, 37 for the yaw estimate). A waiting result stalls only
// the final step. Reset clears the configuration to its defaults, the timing and angle
// history and the search turn to zero; no output is pending after reset.
`default_nettype none

module line_follow_drive_controller_core import lfdc_pkg::*; (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  // Input stream
  input  wire                    s_axis_tvalid,
  output logic                   s_axis_tready,
  // Fields from bit 0: time_stamp[31:0], left_wheel_angle[47:32],
  // right_wheel_angle[63:48], front_range[75:64], left_range[87:76],
  // right_range[99:88], tape_left[100], tape_right[101], tape_center[102], zero[103]
  input  wire  [IN_DATA_W-1:0]   s_axis_tdata,
  // Result stream
  output logic                   m_axis_tvalid,
  input  wire                    m_axis_tready,
  // Fields from bit 0: left_drive[15:0], right_drive[31:16]
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,
  // Configuration write channel
  input  wire                    cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire  [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire  [CFG_DATA_W-1:0]  cfg_data_i
);

  // Sequencer
  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          uw;
  logic            in_fire;
  logic            out_free;
  logic            emit;

  // Configuration
  logic [15:0] radius_q, base_len_q;
  logic [11:0] front_alert_q, front_stop_q, side_alert_q, side_turn_q;

  // History
  logic [31:0]        last_stamp_q;
  logic [15:0]        prev_left_q, prev_right_q;
  logic signed [2:0]  search_turn_q, search_turn_d;

  // Captured input item
  logic [31:0] stamp_q;
  logic [15:0] left_ang_q, right_ang_q;
  logic [11:0] front_rng_q, left_rng_q, right_rng_q;
  logic        tape_l_q, tape_r_q, tape_c_q;

  // Working registers
  logic [31:0]              dt_q;
  logic signed [16:0]       dl_q, dr_q;
  logic [9:0]               speed_q, speed_d;
  logic signed [11:0]       turn_q, turn_d;
  logic signed [34:0]       prod_q;
  logic [47:0]              bdt_q;
  logic [DIVR_W-1:0]        divr_q, rem_q;
  logic [QUO_W-1:0]         quo_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     neg_q;
  logic signed [24:0]       aspeed_q;
  logic signed [37:0]       aturn_q;
  logic signed [25:0]       base_q;
  logic signed [38:0]       tf_q;
  logic [15:0]              left_q, right_q;
  logic                     m_valid_q;

  // Combinational datapath values
  logic signed [17:0] mul_a;
  logic signed [34:0] prod_w;
  logic [15:0]        base_eff;
  logic [47:0]        bdt_w;
  logic [34:0]        prod_mag;
  logic [DIVR_W:0]    trial;
  logic               trial_ge;
  logic [24:0]        spd_q_mag;
  logic [37:0]        trn_q_mag;
  logic signed [39:0] left_w, right_w;
  logic               obstacle;

  // Control word fetch and handshakes
  assign uw            = ucode_rom(pc_q);
  assign s_axis_tready = (uw.op == OP_WAIT);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~m_valid_q | m_axis_tready;
  assign emit          = (uw.op == OP_EMIT) & out_free;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {right_q, left_q};

  // Next step of the program
  always_comb begin
    case (uw.seq)
      SEQ_NEXT:     pc_d = pc_q + 1'b1;
      SEQ_WAIT_IN:  pc_d = in_fire ? pc_q + 1'b1 : pc_q;
      SEQ_JUMP_DT0: pc_d = (dt_q == 32'd0) ? uw.target : pc_q + 1'b1;
      SEQ_LOOP_DIV: pc_d = (cnt_q == 6'd1) ? pc_q + 1'b1 : pc_q;
      SEQ_WAIT_OUT: pc_d = out_free ? uw.target : pc_q;
      default:      pc_d = PC_IDLE;
    endcase
  end

  // Target speed and turn from the tape flags and the sonar ranges
  always_comb begin
    obstacle = (front_rng_q < front_alert_q) | (left_rng_q < side_alert_q) |
               (right_rng_q < side_alert_q);
    if (tape_c_q) begin
      speed_d = SPEED_ON_LINE;
      if (tape_r_q) begin
        turn_d = TURN_HARD_R;
      end else if (tape_l_q) begin
        turn_d = TURN_HARD_L;
      end else begin
        turn_d = TURN_NONE;
      end
    end else begin
      speed_d = SPEED_OFF_LINE;
      if (tape_r_q) begin
        turn_d = TURN_SOFT_R;
      end else if (tape_l_q) begin
        turn_d = TURN_SOFT_L;
      end else begin
        turn_d = {search_turn_q[2], search_turn_q, 8'h00};
      end
    end
    if (obstacle) begin
      if (front_rng_q < front_stop_q) begin
        speed_d = 10'd0;
      end
      if ((right_rng_q < side_turn_q) && (left_rng_q > right_rng_q)) begin
        turn_d = TURN_HARD_L;
      end else begin
        turn_d = TURN_HARD_R;
      end
    end
  end

  // The search turn remembers the last side tape seen, left winning
  always_comb begin
    search_turn_d = search_turn_q;
    if (tape_r_q) begin
      search_turn_d = SEARCH_RIGHT;
    end
    if (tape_l_q) begin
      search_turn_d = SEARCH_LEFT;
    end
  end

  // Multipliers, divider step and final sums
  always_comb begin
    if (uw.op == OP_MUL_DIF) begin
      mul_a = 18'(dr_q) - 18'(dl_q);
    end else begin
      mul_a = 18'(dl_q) + 18'(dr_q);
    end
    prod_w    = 35'(mul_a) * 35'($signed({1'b0, radius_q}));
    base_eff  = (base_len_q == 16'd0) ? 16'd1 : base_len_q;
    bdt_w     = 48'(base_eff) * 48'(dt_q);
    prod_mag  = prod_q[34] ? 35'(-prod_q) : 35'(prod_q);
    trial     = {rem_q, quo_q[QUO_W-1]};
    trial_ge  = (trial >= {1'b0, divr_q});
    spd_q_mag = {1'b0, quo_q[23:0]};
    trn_q_mag = {1'b0, quo_q};
    left_w    = 40'(base_q) - 40'(tf_q);
    right_w   = 40'(base_q) + 40'(tf_q);
  end

  // Control state: sequencer, configuration, history and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q          <= PC_IDLE;
      m_valid_q     <= 1'b0;
      radius_q      <= 16'd4096;
      base_len_q    <= 16'd8192;
      front_alert_q <= 12'd1280;
      front_stop_q  <= 12'd768;
      side_alert_q  <= 12'd512;
      side_turn_q   <= 12'd768;
      last_stamp_q  <= 32'd0;
      prev_left_q   <= 16'd0;
      prev_right_q  <= 16'd0;
      search_turn_q <= SEARCH_NONE;
    end else begin
      pc_q <= pc_d;
      if (emit) begin
        m_valid_q    <= 1'b1;
        last_stamp_q <= stamp_q;
        prev_left_q  <= left_ang_q;
        prev_right_q <= right_ang_q;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (uw.op == OP_PREP) begin
        search_turn_q <= search_turn_d;
      end
      if (cfg_valid_i & cfg_ready_o) begin
        case (cfg_index_i)
          REG_WHEEL_RADIUS: radius_q      <= cfg_data_i;
          REG_WHEEL_BASE:   base_len_q    <= cfg_data_i;
          REG_FRONT_ALERT:  front_alert_q <= cfg_data_i[11:0];
          REG_FRONT_STOP:   front_stop_q  <= cfg_data_i[11:0];
          REG_SIDE_ALERT:   side_alert_q  <= cfg_data_i[11:0];
          REG_SIDE_TURN:    side_turn_q   <= cfg_data_i[11:0];
          default:          ;
        endcase
      end
    end
  end

  // Payload registers, driven by the current control word
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stamp_q     <= s_axis_tdata[31:0];
      left_ang_q  <= s_axis_tdata[47:32];
      right_ang_q <= s_axis_tdata[63:48];
      front_rng_q <= s_axis_tdata[75:64];
      left_rng_q  <= s_axis_tdata[87:76];
      right_rng_q <= s_axis_tdata[99:88];
      tape_l_q    <= s_axis_tdata[100];
      tape_r_q    <= s_axis_tdata[101];
      tape_c_q    <= s_axis_tdata[102];
    end
    case (uw.op)
      OP_PREP: begin
        dt_q    <= stamp_q - last_stamp_q;
        dl_q    <= wrap_delta(left_ang_q, prev_left_q);
        dr_q    <= wrap_delta(right_ang_q, prev_right_q);
        speed_q <= speed_d;
        turn_q  <= turn_d;
      end
      OP_MUL_SUM, OP_MUL_DIF: begin
        prod_q <= prod_w;
      end
      OP_MUL_BDT: begin
        bdt_q <= bdt_w;
      end
      OP_LOAD_SPD: begin
        // Dividing by dt*256 equals dividing the magnitude shifted down by 8 by dt.
        quo_q  <= {prod_mag[31:8], 13'd0};
        rem_q  <= '0;
        divr_q <= {16'd0, dt_q};
        cnt_q  <= SPD_ITERS;
        neg_q  <= prod_q[34];
      end
      OP_LOAD_TRN: begin
        // The factor 32 on the numerator is a left shift by five.
        quo_q  <= {prod_mag[31:0], 5'd0};
        rem_q  <= '0;
        divr_q <= bdt_q;
        cnt_q  <= TRN_ITERS;
        neg_q  <= prod_q[34];
      end
      OP_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (trial_ge) begin
          rem_q <= DIVR_W'(trial - {1'b0, divr_q});
        end else begin
          rem_q <= trial[DIVR_W-1:0];
        end
        quo_q <= {quo_q[QUO_W-2:0], trial_ge};
        cnt_q <= cnt_q - 1'b1;
      end
      OP_STORE_SPD: begin
        aspeed_q <= neg_q ? -$signed(spd_q_mag) : $signed(spd_q_mag);
      end
      OP_STORE_TRN: begin
        aturn_q <= neg_q ? -$signed(trn_q_mag) : $signed(trn_q_mag);
      end
      OP_SUM: begin
        base_q <= $signed({16'd0, speed_q}) - 26'(aspeed_q);
        tf_q   <= 39'(turn_q) - 39'(aturn_q);
      end
      OP_EMIT: begin
        if (out_free) begin
          left_q  <= sat16(left_w);
          right_q <= sat16(right_w);
        end
      end
      default: ;
    endcase
  end

  // The divider count is never exhausted while a division step runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.op == OP_DIV) |-> (cnt_q != '0))
    else $error("divider step with zero count");

  // A result only appears after the final step of the program.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> ($past(uw.op) == OP_EMIT))
    else $error("result raised outside the emit step");

  // The search turn holds only left, right or none.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (search_turn_q == SEARCH_NONE) || (search_turn_q == SEARCH_LEFT) ||
    (search_turn_q == SEARCH_RIGHT))
    else $error("search turn out of range");

  // The program counter stays inside the program.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= PC_LAST)
    else $error("program counter beyond the last step");

  // An input transfer always starts the program at its preparation step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (uw.op == OP_PREP))
    else $error("input transfer did not start the program");

endmodule

`default_nettype wire
